// ===== rtl/eroc_pkg.sv =====
// shared types, codes and constants of the echo range occupancy counter
package eroc_pkg;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_EDGE  = 2'd1,
    KIND_EVAL  = 2'd2,
    KIND_EXIT  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    OP_START,
    OP_CAPTURE,
    OP_MEASURE,
    OP_EVAL,
    OP_EXIT
  } op_t;

  typedef enum logic [1:0] {
    CFG_NEAR = 2'd0,
    CFG_FAR  = 2'd1,
    CFG_CAP  = 2'd2
  } cfg_idx_t;

  localparam int STAMP_W  = 32;
  localparam int DIST_W   = 16;
  localparam int COUNT_W  = 8;
  localparam int BAND_W   = 2;
  localparam int CFG_IDX_W = 2;

  // smallest echo time whose distance no longer fits in 16 bits
  localparam logic [STAMP_W-1:0] DT_SAT = 32'd381024;
  localparam int DT_W = 19;
  // floor(dt * 43 / 250) == (dt * DIST_MUL) >> DIST_SHIFT for dt < 2**19
  localparam int MUL_W = 25;
  localparam logic [MUL_W-1:0] DIST_MUL = 25'd23085450;
  localparam int DIST_SHIFT = 27;
  localparam int PROD_W = DT_W + MUL_W;

  localparam logic [DIST_W-1:0]  NEAR_RESET = 16'd10;
  localparam logic [DIST_W-1:0]  FAR_RESET  = 16'd200;
  localparam logic [COUNT_W-1:0] CAP_RESET  = 8'd4;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = 8'd255;

  typedef struct packed {
    op_t              op;
    logic [DIST_W-1:0] meas;
  } work_t;

  typedef struct packed {
    logic [DIST_W-1:0]  near_limit;
    logic [DIST_W-1:0]  far_limit;
    logic [COUNT_W-1:0] capacity;
  } cfg_t;

  typedef struct packed {
    logic [DIST_W-1:0]  distance;
    logic               car_seen;
    logic [COUNT_W-1:0] car_count;
    logic [BAND_W-1:0]  sign_band;
    logic               sign_update;
    logic               exit_ack;
  } result_t;

  // quarter band of count against cap with exact integer compares
  function automatic logic [BAND_W-1:0] band_of(input logic [COUNT_W-1:0] count,
                                                input logic [COUNT_W-1:0] cap);
    logic [COUNT_W+1:0] c4;
    logic [COUNT_W+1:0] c2;
    logic [COUNT_W+1:0] cp;
    logic [COUNT_W+1:0] cp3;
    logic [BAND_W-1:0]  band;
    c4  = {count, 2'b00};
    c2  = {1'b0, count, 1'b0};
    cp  = {2'b00, cap};
    cp3 = cp + {1'b0, cap, 1'b0};
    priority if (c4 <= cp) begin
      band = 2'd0;
    end else if (c2 <= cp) begin
      band = 2'd1;
    end else if (c4 <= cp3) begin
      band = 2'd2;
    end else begin
      band = 2'd3;
    end
    return band;
  endfunction

endpackage

// ===== rtl/eroc_ifs.sv =====
// channel interfaces: input items, results and configuration writes
interface eroc_in_if import eroc_pkg::*; ();
  logic                valid;
  logic                ready;
  kind_t               kind;
  logic [STAMP_W-1:0]  timer_stamp;

  modport source (output valid, kind, timer_stamp, input ready);
  modport sink (input valid, kind, timer_stamp, output ready);
endinterface

interface eroc_out_if import eroc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DIST_W-1:0]  distance;
  logic               car_seen;
  logic [COUNT_W-1:0] car_count;
  logic [BAND_W-1:0]  sign_band;
  logic               sign_update;
  logic               exit_ack;

  modport source (output valid, distance, car_seen, car_count, sign_band, sign_update,
                  exit_ack, input ready);
  modport sink (input valid, distance, car_seen, car_count, sign_band, sign_update,
                exit_ack, output ready);
endinterface

interface eroc_cfg_if import eroc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DIST_W-1:0]    wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface

// ===== rtl/eroc_front.sv =====
// front end: accepts items, tracks the echo start and computes the distance
module eroc_front import eroc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  eroc_in_if.sink     in_ch,
  output logic        wk_valid,
  input  logic        wk_ready,
  output work_t       wk_data
);

  logic [STAMP_W-1:0] echo_start_r, echo_start_nxt;
  logic               captured_r, captured_nxt;

  logic               s1_v_r;
  op_t                s1_op_r;
  logic [DT_W-1:0]    s1_dt_r;
  logic               s1_sat_r;
  logic               s2_v_r;
  work_t              s2_r;

  logic               s1_ready;
  logic               s2_ready;
  logic               accept;
  op_t                op_nxt;
  logic [STAMP_W-1:0] dt;
  logic [PROD_W-1:0]  prod;
  logic [DIST_W-1:0]  meas_val;

  assign s2_ready    = !s2_v_r || wk_ready;
  assign s1_ready    = !s1_v_r || s2_ready;
  assign in_ch.ready = s1_ready;
  assign accept      = in_ch.valid && s1_ready;

  assign dt = in_ch.timer_stamp - echo_start_r;

  always_comb begin
    op_nxt         = OP_EXIT;
    echo_start_nxt = echo_start_r;
    captured_nxt   = captured_r;
    unique case (in_ch.kind)
      KIND_START: begin
        op_nxt         = OP_START;
        echo_start_nxt = '0;
        captured_nxt   = 1'b0;
      end
      KIND_EDGE: begin
        if (captured_r) begin
          op_nxt = OP_MEASURE;
        end else begin
          op_nxt         = OP_CAPTURE;
          echo_start_nxt = in_ch.timer_stamp;
          captured_nxt   = 1'b1;
        end
      end
      KIND_EVAL: begin
        op_nxt = OP_EVAL;
      end
      KIND_EXIT: begin
        op_nxt = OP_EXIT;
      end
    endcase
  end

  // distance = floor(172 * dt / 1000), done as one reciprocal multiply
  assign prod     = {{MUL_W{1'b0}}, s1_dt_r} * {{DT_W{1'b0}}, DIST_MUL};
  assign meas_val = s1_sat_r ? {DIST_W{1'b1}} : prod[DIST_SHIFT +: DIST_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      echo_start_r <= '0;
      captured_r   <= 1'b0;
      s1_v_r       <= 1'b0;
      s2_v_r       <= 1'b0;
    end else begin
      if (accept) begin
        echo_start_r <= echo_start_nxt;
        captured_r   <= captured_nxt;
      end
      if (s1_ready) begin
        s1_v_r <= in_ch.valid;
      end
      if (s2_ready) begin
        s2_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_op_r  <= op_nxt;
      s1_dt_r  <= dt[DT_W-1:0];
      s1_sat_r <= (dt >= DT_SAT);
    end
    if (s2_ready) begin
      s2_r.op   <= s1_op_r;
      s2_r.meas <= meas_val;
    end
  end

  assign wk_valid = s2_v_r;
  assign wk_data  = s2_r;

endmodule

// ===== rtl/eroc_queue.sv =====
// two-entry queue between the front end and the back end
module eroc_queue import eroc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  work_t push_data,
  output logic  pop_valid,
  input  logic  pop_ready,
  output work_t pop_data
);

  localparam logic [1:0] DEPTH = 2'd2;

  work_t      slots_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  logic       pop;

  assign push_ready = (cnt_r != DEPTH);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = slots_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/eroc_back.sv =====
// back end: presence, car count and band state, plus the result register
module eroc_back import eroc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wk_valid,
  output logic        wk_ready,
  input  work_t       wk_data,
  input  cfg_t        cfg,
  eroc_out_if.source  out_ch
);

  logic [DIST_W-1:0]  range_r, range_nxt;
  logic               was_r, was_nxt;
  logic               present_r, present_nxt;
  logic [COUNT_W-1:0] occ_r, occ_nxt;
  logic [BAND_W-1:0]  band_r, band_nxt;
  logic               shown_r, shown_nxt;
  logic               out_v_r;
  result_t            res_r;

  logic               take;
  logic               upd;
  logic               ack;
  logic               pres_eval;
  logic [COUNT_W-1:0] occ_eval;
  logic [BAND_W-1:0]  band_eval;

  assign wk_ready = !out_v_r || out_ch.ready;
  assign take     = wk_valid && wk_ready;

  assign pres_eval = (range_r > cfg.near_limit) && (range_r < cfg.far_limit);
  // a car that leaves the sensor range has driven in
  assign occ_eval  = (was_r && !pres_eval && (occ_r != COUNT_MAX)) ? occ_r + 8'd1 : occ_r;
  assign band_eval = band_of(occ_eval, cfg.capacity);

  always_comb begin
    range_nxt   = range_r;
    was_nxt     = was_r;
    present_nxt = present_r;
    occ_nxt     = occ_r;
    band_nxt    = band_r;
    shown_nxt   = shown_r;
    upd         = 1'b0;
    ack         = 1'b0;
    unique case (wk_data.op)
      OP_START: begin
        range_nxt = '0;
      end
      OP_CAPTURE: begin
      end
      OP_MEASURE: begin
        range_nxt = wk_data.meas;
      end
      OP_EVAL: begin
        present_nxt = pres_eval;
        occ_nxt     = occ_eval;
        if (was_r) begin
          if (!pres_eval) begin
            was_nxt = 1'b0;
          end
        end else if (pres_eval) begin
          was_nxt = 1'b1;
        end
        if (!shown_r || (band_eval != band_r)) begin
          band_nxt  = band_eval;
          shown_nxt = 1'b1;
          upd       = 1'b1;
        end
      end
      OP_EXIT: begin
        if (occ_r != '0) begin
          occ_nxt = occ_r - 8'd1;
        end
        ack = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_r   <= '0;
      was_r     <= 1'b0;
      present_r <= 1'b0;
      occ_r     <= '0;
      band_r    <= '0;
      shown_r   <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      if (wk_ready) begin
        out_v_r <= wk_valid;
      end
      if (take) begin
        range_r   <= range_nxt;
        was_r     <= was_nxt;
        present_r <= present_nxt;
        occ_r     <= occ_nxt;
        band_r    <= band_nxt;
        shown_r   <= shown_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r.distance    <= range_nxt;
      res_r.car_seen    <= present_nxt;
      res_r.car_count   <= occ_nxt;
      res_r.sign_band   <= band_nxt;
      res_r.sign_update <= upd;
      res_r.exit_ack    <= ack;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.distance    = res_r.distance;
  assign out_ch.car_seen    = res_r.car_seen;
  assign out_ch.car_count   = res_r.car_count;
  assign out_ch.sign_band   = res_r.sign_band;
  assign out_ch.sign_update = res_r.sign_update;
  assign out_ch.exit_ack    = res_r.exit_ack;

`ifndef SYNTHESIS
  a_update_only_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (take && (wk_data.op != OP_EVAL)) |=> !res_r.sign_update)
    else $error("sign update on a beat that is not an evaluate");

  a_ack_matches_exit: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> (out_v_r && (res_r.exit_ack == $past(wk_data.op == OP_EXIT))))
    else $error("exit acknowledge does not match the beat kind");

  a_count_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (take && (wk_data.op == OP_EXIT) && (occ_r == '0)) |=> (occ_r == '0))
    else $error("car count wrapped below zero");
`endif

endmodule

// ===== rtl/echo_range_occupancy_counter.sv =====
// top level: configuration registers, front end, queue and back end
// a result passes front-end stages s1 and s2, the queue and the back-end result register
// throughput: one item per cycle while results are taken; the reciprocal multiply for the
//   distance sits in its own front-end stage, so it never limits the rate
// the two-entry queue lets the front end keep accepting while a result is stalled
// reset: synchronous active-low rst_n clears control state, loads register defaults
module echo_range_occupancy_counter import eroc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  eroc_in_if.sink     in_ch,
  eroc_out_if.source  out_ch,
  eroc_cfg_if.sink    cfg_ch
);

  cfg_t  cfg_r;
  logic  fq_valid;
  logic  fq_ready;
  work_t fq_data;
  logic  qb_valid;
  logic  qb_ready;
  work_t qb_data;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.near_limit <= NEAR_RESET;
      cfg_r.far_limit  <= FAR_RESET;
      cfg_r.capacity   <= CAP_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_NEAR: cfg_r.near_limit <= cfg_ch.wdata;
        CFG_FAR:  cfg_r.far_limit  <= cfg_ch.wdata;
        CFG_CAP:  cfg_r.capacity   <= cfg_ch.wdata[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  eroc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .wk_valid (fq_valid),
    .wk_ready (fq_ready),
    .wk_data  (fq_data)
  );

  eroc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_data)
  );

  eroc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .wk_valid (qb_valid),
    .wk_ready (qb_ready),
    .wk_data  (qb_data),
    .cfg      (cfg_r),
    .out_ch   (out_ch)
  );

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for the echo range occupancy counter, directed and random beats
`timescale 1ns / 1ps

module testbench;
  import eroc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    kind_t              kind;
    logic [STAMP_W-1:0] stamp;
  } beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  eroc_in_if  in_if ();
  eroc_out_if out_if ();
  eroc_cfg_if cfg_if ();

  echo_range_occupancy_counter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted copy of the block's registers and state
  logic [DIST_W-1:0]  lim_near = 16'd10;
  logic [DIST_W-1:0]  lim_far = 16'd200;
  logic [COUNT_W-1:0] cap_places = 8'd4;
  logic [STAMP_W-1:0] echo_t0 = '0;
  logic               t0_held = 1'b0;
  logic [DIST_W-1:0]  range_now = '0;
  logic               car_was_in = 1'b0;
  logic               car_in_view = 1'b0;
  logic [COUNT_W-1:0] cars_inside = '0;
  logic [BAND_W-1:0]  band_shown = '0;
  logic               band_known = 1'b0;

  beat_t   pending_beats[$];
  result_t status_due[$];

  int          errors = 0;
  int unsigned cycles = 0;
  bit          pacing = 1'b1;
  int          tx_gap = 0;
  int          rx_hold = 0;
  logic        in_fire = 1'b0;
  logic        out_fire = 1'b0;

  function automatic logic [BAND_W-1:0] occupancy_band(input logic [COUNT_W-1:0] count,
                                                       input logic [COUNT_W-1:0] cap);
    int c;
    int p;
    c = count;
    p = cap;
    if (4 * c <= p) return 2'd0;
    if (2 * c <= p) return 2'd1;
    if (4 * c <= 3 * p) return 2'd2;
    return 2'd3;
  endfunction

  task automatic advance_status(input kind_t k, input logic [STAMP_W-1:0] stamp,
                                output result_t r);
    logic [STAMP_W-1:0] dt;
    logic [63:0]        scaled;
    logic [BAND_W-1:0]  band;
    logic               upd;
    logic               ack;
    upd = 1'b0;
    ack = 1'b0;
    case (k)
      KIND_START: begin
        range_now = '0;
        echo_t0 = '0;
        t0_held = 1'b0;
      end
      KIND_EDGE: begin
        if (!t0_held) begin
          echo_t0 = stamp;
          t0_held = 1'b1;
        end else begin
          dt = stamp - echo_t0;
          scaled = ({32'd0, dt} * 64'd172) / 64'd1000;
          range_now = (scaled > 64'd65535) ? 16'hFFFF : scaled[DIST_W-1:0];
        end
      end
      KIND_EVAL: begin
        car_in_view = (range_now > lim_near) && (range_now < lim_far);
        if (car_was_in) begin
          // car drove off the sensor: counted in
          if (!car_in_view) begin
            if (cars_inside != 8'd255) cars_inside = cars_inside + 8'd1;
            car_was_in = 1'b0;
          end
        end else if (car_in_view) begin
          car_was_in = 1'b1;
        end
        band = occupancy_band(cars_inside, cap_places);
        if (!band_known || band != band_shown) begin
          band_shown = band;
          band_known = 1'b1;
          upd = 1'b1;
        end
      end
      default: begin
        if (cars_inside != 8'd0) cars_inside = cars_inside - 8'd1;
        ack = 1'b1;
      end
    endcase
    r.distance = range_now;
    r.car_seen = car_in_view;
    r.car_count = cars_inside;
    r.sign_band = band_shown;
    r.sign_update = upd;
    r.exit_ack = ack;
  endtask

  task automatic report_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
      errors++;
    end
  endtask

  function automatic int pick_gap();
    int r;
    if (!pacing) return 0;
    r = $urandom_range(99, 0);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(80, 20);
  endfunction

  // smallest echo time that reaches distance d
  function automatic logic [STAMP_W-1:0] dt_for(input int d);
    return (d * 1000 + 171) / 172;
  endfunction

  function automatic logic [STAMP_W-1:0] pick_dt();
    int r;
    int lo;
    int hi;
    r = $urandom_range(99, 0);
    lo = (lim_near < lim_far) ? lim_near : lim_far;
    hi = (lim_near < lim_far) ? lim_far : lim_near;
    if (hi > 65533) hi = 65533;
    if (r < 60) return dt_for($urandom_range(hi + 2, lo)) + $urandom_range(6, 0);
    if (r < 75) return $urandom_range(200, 0);
    // around the point where the distance saturates
    if (r < 88) return 32'd381016 + $urandom_range(16, 0);
    return $urandom;
  endfunction

  task automatic queue_beat(input kind_t k, input logic [STAMP_W-1:0] s);
    beat_t b;
    b.kind = k;
    b.stamp = s;
    pending_beats.push_back(b);
  endtask

  task automatic queue_noise();
    repeat ($urandom_range(4, 1)) queue_beat(kind_t'($urandom_range(3, 0)), $urandom);
  endtask

  // start, capture, measure, evaluate, maybe measure and evaluate again, leave the sensor, evaluate again, maybe exit
  task automatic queue_car();
    logic [STAMP_W-1:0] s0;
    s0 = $urandom;
    queue_beat(KIND_START, $urandom);
    queue_beat(KIND_EDGE, s0);
    queue_beat(KIND_EDGE, s0 + pick_dt());
    queue_beat(KIND_EVAL, $urandom);
    if ($urandom_range(2, 0) == 0) begin
      queue_beat(KIND_EDGE, s0 + pick_dt());
      queue_beat(KIND_EVAL, $urandom);
    end
    if ($urandom_range(1, 0) == 0) queue_beat(KIND_START, $urandom);
    else queue_beat(KIND_EDGE, s0);
    queue_beat(KIND_EVAL, $urandom);
    if ($urandom_range(3, 0) == 0) queue_beat(KIND_EXIT, $urandom);
  endtask

  // checked at the rising edge, where valid and the queues are settled
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_beats.size() != 0 || in_if.valid || status_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [DIST_W-1:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.wdata <= val;
    do @(posedge clk);
    while (!cfg_if.ready);
    case (idx)
      CFG_NEAR: lim_near = val;
      CFG_FAR:  lim_far = val;
      default:  cap_places = val[COUNT_W-1:0];
    endcase
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_limits(input logic [DIST_W-1:0] near_v, input logic [DIST_W-1:0] far_v,
                            input logic [DIST_W-1:0] cap_v);
    write_reg(CFG_NEAR, near_v);
    write_reg(CFG_FAR, far_v);
    write_reg(CFG_CAP, cap_v);
  endtask

  task automatic run_phase(input int cars, input int noise_pct, input bit paced);
    @(posedge clk);
    pacing = paced;
    repeat (cars) begin
      if ($urandom_range(99, 0) < noise_pct) queue_noise();
      queue_car();
    end
    wait_drained();
  endtask

  // fills the lot to saturation with compact in/out sequences
  task automatic fill_lot(input int cars);
    logic [STAMP_W-1:0] s0;
    @(posedge clk);
    pacing = 1'b1;
    s0 = $urandom;
    queue_beat(KIND_START, $urandom);
    queue_beat(KIND_EDGE, s0);
    for (int i = 0; i < cars; i++) begin
      if (i == cars / 2) begin
        // hold the sender until every result so far is back
        wait_drained();
        @(posedge clk);
      end
      queue_beat(KIND_EDGE, s0 + dt_for($urandom_range(lim_far - 1, lim_near + 1)));
      queue_beat(KIND_EVAL, $urandom);
      queue_beat(KIND_EDGE, s0 + $urandom_range(dt_for(lim_near + 1) - 1, 0));
      queue_beat(KIND_EVAL, $urandom);
    end
    wait_drained();
  endtask

  // input side: one beat per handshake, random gaps between beats when pacing is on
  always @(negedge clk) begin
    beat_t nxt;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (in_if.valid && !in_fire) begin
      // beat still waiting for ready
    end else if (tx_gap > 0) begin
      in_if.valid <= 1'b0;
      tx_gap <= tx_gap - 1;
    end else if (pending_beats.size() != 0) begin
      nxt = pending_beats.pop_front();
      in_if.valid <= 1'b1;
      in_if.kind <= nxt.kind;
      in_if.timer_stamp <= nxt.stamp;
      tx_gap <= pick_gap();
    end else begin
      in_if.valid <= 1'b0;
    end
  end

  // result side backpressure
  always @(negedge clk) begin
    int hold;
    hold = rx_hold;
    if (out_fire || (out_if.ready && $urandom_range(7, 0) == 0)) hold = pick_gap();
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold > 0) begin
      out_if.ready <= 1'b0;
      rx_hold <= hold - 1;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // check results first, then predict for the beat taken at this edge
  always @(posedge clk) begin
    result_t want;
    result_t due;
    in_fire <= rst_n && in_if.valid && in_if.ready;
    out_fire <= rst_n && out_if.valid && out_if.ready;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (status_due.size() == 0) begin
        $display("%0t ns: unexpected result, distance %0d count %0d", $time,
                 out_if.distance, out_if.car_count);
        errors++;
      end else begin
        want = status_due.pop_front();
        report_field("distance", want.distance, out_if.distance);
        report_field("car_seen", want.car_seen, out_if.car_seen);
        report_field("car_count", want.car_count, out_if.car_count);
        report_field("sign_band", want.sign_band, out_if.sign_band);
        report_field("sign_update", want.sign_update, out_if.sign_update);
        report_field("exit_ack", want.exit_ack, out_if.exit_ack);
      end
    end
    if (rst_n && in_if.valid && in_if.ready) begin
      advance_status(in_if.kind, in_if.timer_stamp, due);
      status_due.push_back(due);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.kind = KIND_START;
    in_if.timer_stamp = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_NEAR;
    cfg_if.wdata = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part on the reset limits: 10 / 200 / 4 places
    @(posedge clk);
    queue_beat(KIND_EVAL, 32'd0);                          // first evaluate shows a band
    queue_beat(KIND_EXIT, 32'hFFFF_FFFF);                  // exit with an empty lot
    queue_beat(KIND_EDGE, 32'd1000);
    queue_beat(KIND_EDGE, 32'd1000 + dt_for(11));           // just above near
    queue_beat(KIND_EVAL, 32'd0);
    queue_beat(KIND_EDGE, 32'd1000 + dt_for(11) - 32'd1);   // equal to near
    queue_beat(KIND_EVAL, 32'd0);
    queue_beat(KIND_EDGE, 32'd1000 + dt_for(199));          // just below far
    queue_beat(KIND_EVAL, 32'd0);
    queue_beat(KIND_EDGE, 32'd1000 + dt_for(200));          // equal to far
    queue_beat(KIND_EVAL, 32'd0);
    queue_beat(KIND_START, 32'h5A5A_A5A5);
    queue_beat(KIND_EDGE, 32'hFFFF_FF00);
    queue_beat(KIND_EDGE, 32'h0000_0100);                  // timer wraps between edges
    queue_beat(KIND_EVAL, 32'd0);
    queue_beat(KIND_EDGE, 32'hFFFF_FEFF);                  // largest echo time
    queue_beat(KIND_EVAL, 32'd0);
    queue_beat(KIND_START, 32'd0);
    queue_beat(KIND_EDGE, 32'd0);
    queue_beat(KIND_EDGE, 32'd381023);                     // last value that fits
    queue_beat(KIND_EDGE, 32'd381024);                     // first saturated value
    queue_beat(KIND_EXIT, 32'd0);
    queue_beat(KIND_EXIT, 32'd0);
    queue_beat(KIND_EXIT, 32'd0);
    queue_beat(KIND_EVAL, 32'd0);
    queue_beat(KIND_EDGE, 32'd0);                          // zero echo time
    wait_drained();

    set_limits(16'd0, 16'hFFFF, 16'd1);
    run_phase(5, 30, 1'b1);

    // crossed limits: nothing counts as present
    set_limits(16'hFFFF, 16'd0, 16'd255);
    run_phase(3, 30, 1'b0);

    set_limits(16'd5, 16'd300, 16'd255);
    fill_lot(264);

    // zero places, junk above the capacity byte
    set_limits(16'($urandom_range(400, 0)), 16'($urandom_range(600, 100)),
               {8'($urandom), 8'd0});
    @(posedge clk);
    repeat (20) queue_beat(KIND_EXIT, $urandom);
    run_phase(3, 20, 1'b1);

    set_limits(16'($urandom_range(300, 0)), 16'($urandom_range(700, 301)),
               16'($urandom_range(255, 1)));
    run_phase(4, 25, 1'b1);
    set_limits(16'($urandom), 16'($urandom), 16'($urandom));
    run_phase(4, 25, 1'b0);

    set_limits(16'd120, 16'd120, 16'd3);
    run_phase(3, 20, 1'b1);

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
